>>> hdl/nai_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nai_pkg
// Shared types, constants and helpers of the null-aware int64 expression ALU.
// ----------------------------------------------------------------------------
package nai_pkg;

    localparam int ROW_W       = 10;
    localparam int DATA_W      = 64;
    localparam int CMD_W       = 4;
    localparam int QUEUE_DEPTH = 4;
    // one quotient bit per back-end stage
    localparam int DIV_STEPS   = DATA_W;
    // back-end stage at which the multiply result is folded in
    localparam int MUL_STAGE   = 4;
    // cycles from an accepted request to its result strobe
    localparam int LATENCY     = DIV_STEPS + 3;

    localparam logic [DATA_W-1:0] SIGN_BIT = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 4'd0,
        CMD_SUB    = 4'd1,
        CMD_MUL    = 4'd2,
        CMD_DIV    = 4'd3,
        CMD_EQ     = 4'd4,
        CMD_NE     = 4'd5,
        CMD_LT     = 4'd6,
        CMD_LE     = 4'd7,
        CMD_GT     = 4'd8,
        CMD_GE     = 4'd9,
        CMD_AND    = 4'd10,
        CMD_OR     = 4'd11,
        CMD_NOT    = 4'd12,
        CMD_ISNULL = 4'd13
    } t_cmd;

    // classified request, front end to back end
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] res;    // finished result for ops other than mul/div
        logic              vld;    // result valid, or "operands usable" for mul/div
        logic              neg;    // result sign for mul/div
        logic [DATA_W-1:0] mag_a;
        logic [DATA_W-1:0] mag_b;
    } t_job;

    // one back-end pipeline stage
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] res;
        logic              vld;
        logic              neg;
        logic [DATA_W-1:0] rem;    // partial remainder
        logic [DATA_W-1:0] quo;    // dividend shifting out, quotient shifting in
        logic [DATA_W-1:0] dvs;    // divisor magnitude
    } t_stg;

    // one restoring-division step
    function automatic t_stg div_step(input t_stg s);
        t_stg            o;
        logic [DATA_W-1:0] sh;
        logic [DATA_W:0]   diff;
        o    = s;
        sh   = {s.rem[DATA_W-2:0], s.quo[DATA_W-1]};
        diff = {1'b0, sh} - {1'b0, s.dvs};
        if (!diff[DATA_W]) begin
            o.rem = diff[DATA_W-1:0];
            o.quo = {s.quo[DATA_W-2:0], 1'b1};
        end else begin
            o.rem = sh;
            o.quo = {s.quo[DATA_W-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

>>> hdl/nai_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nai_front
// Classifies a request: finishes add/sub/compare/logic ops, prepares
// operand magnitudes and sign for multiply and divide.
// ----------------------------------------------------------------------------
module nai_front (
    input  logic [nai_pkg::CMD_W-1:0]         i_cmd,
    input  logic [nai_pkg::ROW_W-1:0]         i_row_index,
    input  logic signed [nai_pkg::DATA_W-1:0] i_operand_a,
    input  logic                              i_operand_a_valid,
    input  logic signed [nai_pkg::DATA_W-1:0] i_operand_b,
    input  logic                              i_operand_b_valid,
    output nai_pkg::t_job                     o_job
);

    logic                          both;
    logic [nai_pkg::DATA_W-1:0]    sum;
    logic [nai_pkg::DATA_W-1:0]    dif;
    logic                          add_ovf;
    logic                          sub_ovf;
    logic                          lt_ab;
    logic                          lt_ba;
    logic                          x_true;
    logic                          y_true;
    logic [nai_pkg::DATA_W-1:0]    res;
    logic                          vld;

    assign both   = i_operand_a_valid & i_operand_b_valid;
    assign sum    = i_operand_a + i_operand_b;
    assign dif    = i_operand_a - i_operand_b;
    assign lt_ab  = i_operand_a < i_operand_b;
    assign lt_ba  = i_operand_b < i_operand_a;
    assign x_true = i_operand_a != '0;
    assign y_true = i_operand_b != '0;

    // signed overflow: operand signs vs. result sign
    assign add_ovf = ~(i_operand_a[nai_pkg::DATA_W-1] ^ i_operand_b[nai_pkg::DATA_W-1])
                     & (i_operand_a[nai_pkg::DATA_W-1] ^ sum[nai_pkg::DATA_W-1]);
    assign sub_ovf = (i_operand_a[nai_pkg::DATA_W-1] ^ i_operand_b[nai_pkg::DATA_W-1])
                     & (i_operand_a[nai_pkg::DATA_W-1] ^ dif[nai_pkg::DATA_W-1]);

    // per-op result and null flag
    always_comb begin
        res = '0;
        vld = 1'b0;
        unique case (nai_pkg::t_cmd'(i_cmd))
            nai_pkg::CMD_ADD: begin
                res = sum;
                vld = both & ~add_ovf;
            end
            nai_pkg::CMD_SUB: begin
                res = dif;
                vld = both & ~sub_ovf;
            end
            // finished in the back end
            nai_pkg::CMD_MUL: vld = both;
            nai_pkg::CMD_DIV: begin
                vld = both && (i_operand_b != '0)
                      && !((i_operand_a == nai_pkg::SIGN_BIT) && (i_operand_b == '1));
            end
            nai_pkg::CMD_EQ: begin
                res = {{(nai_pkg::DATA_W-1){1'b0}}, i_operand_a == i_operand_b};
                vld = both;
            end
            nai_pkg::CMD_NE: begin
                res = {{(nai_pkg::DATA_W-1){1'b0}}, i_operand_a != i_operand_b};
                vld = both;
            end
            nai_pkg::CMD_LT: begin
                res = {{(nai_pkg::DATA_W-1){1'b0}}, lt_ab};
                vld = both;
            end
            nai_pkg::CMD_LE: begin
                res = {{(nai_pkg::DATA_W-1){1'b0}}, ~lt_ba};
                vld = both;
            end
            nai_pkg::CMD_GT: begin
                res = {{(nai_pkg::DATA_W-1){1'b0}}, lt_ba};
                vld = both;
            end
            nai_pkg::CMD_GE: begin
                res = {{(nai_pkg::DATA_W-1){1'b0}}, ~lt_ab};
                vld = both;
            end
            // Kleene logic: a known false decides AND, a known true decides OR
            nai_pkg::CMD_AND: begin
                res = {{(nai_pkg::DATA_W-1){1'b0}}, x_true & y_true};
                vld = both | (i_operand_a_valid & ~x_true) | (i_operand_b_valid & ~y_true);
            end
            nai_pkg::CMD_OR: begin
                res = {{(nai_pkg::DATA_W-1){1'b0}}, x_true | y_true};
                vld = both | (i_operand_a_valid & x_true) | (i_operand_b_valid & y_true);
            end
            nai_pkg::CMD_NOT: begin
                res = {{(nai_pkg::DATA_W-1){1'b0}}, ~x_true};
                vld = i_operand_a_valid;
            end
            nai_pkg::CMD_ISNULL: begin
                res = {{(nai_pkg::DATA_W-1){1'b0}}, ~i_operand_a_valid};
                vld = 1'b1;
            end
            default: begin
                res = '0;
                vld = 1'b0;
            end
        endcase
    end

    // null results read as zero
    always_comb begin
        o_job.row   = i_row_index;
        o_job.cmd   = i_cmd;
        o_job.res   = vld ? res : '0;
        o_job.vld   = vld;
        o_job.neg   = i_operand_a[nai_pkg::DATA_W-1] ^ i_operand_b[nai_pkg::DATA_W-1];
        o_job.mag_a = i_operand_a[nai_pkg::DATA_W-1] ? (~i_operand_a + 1'b1) : i_operand_a;
        o_job.mag_b = i_operand_b[nai_pkg::DATA_W-1] ? (~i_operand_b + 1'b1) : i_operand_b;
    end

endmodule

>>> hdl/nai_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nai_queue
// Short register FIFO of classified requests between front and back end.
// ----------------------------------------------------------------------------
module nai_queue #(
    parameter int DEPTH = nai_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  nai_pkg::t_job i_data,
    input  logic          i_pop,
    output nai_pkg::t_job o_data,
    output logic          o_empty,
    output logic          o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    nai_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_empty = r_cnt == '0;
    assign o_full  = r_cnt == FULL;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    // pointer and count update
    always_comb begin
        n_wr  = do_push ? ((r_wr == LAST) ? '0 : r_wr + 1'b1) : r_wr;
        n_rd  = do_pop  ? ((r_rd == LAST) ? '0 : r_rd + 1'b1) : r_rd;
        n_cnt = r_cnt + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> hdl/nai_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nai_back
// Execution pipeline: one restoring-divide bit per stage, a split 64x64
// multiplier alongside the first stages, quotient sign and null fix-up at the end.
// ----------------------------------------------------------------------------
module nai_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  nai_pkg::t_job                     i_job,
    output logic                              o_strobe,
    output logic [nai_pkg::ROW_W-1:0]         o_out_row_index,
    output logic signed [nai_pkg::DATA_W-1:0] o_result_value,
    output logic                              o_result_valid
);

    localparam int NS = nai_pkg::DIV_STEPS + 1;
    localparam int HW = nai_pkg::DATA_W / 2;
    localparam int DW = nai_pkg::DATA_W;

    nai_pkg::t_stg r_stg [NS];
    nai_pkg::t_stg n_stg [NS];
    logic [NS-1:0] r_sv, n_sv;

    // multiplier partial products and sums
    logic [DW-1:0]   r_pp_ll, r_pp_lh, r_pp_hl, r_pp_hh;
    logic [DW-1:0]   r_m2_ll, r_m2_hh;
    logic [DW:0]     r_m2_mid;
    logic [2*DW-1:0] r_prod;

    logic [DW-1:0] mul_lo;
    logic [DW-1:0] mul_lim;
    logic          mul_ok;

    logic          r_strobe;
    logic [nai_pkg::ROW_W-1:0] r_row;
    logic [DW-1:0] r_val, n_val;
    logic          r_vld, n_vld;

    // multiply overflow check and sign
    assign mul_lo  = r_prod[DW-1:0];
    assign mul_lim = r_stg[nai_pkg::MUL_STAGE-1].neg ? nai_pkg::SIGN_BIT
                                                     : ~nai_pkg::SIGN_BIT;
    assign mul_ok  = r_stg[nai_pkg::MUL_STAGE-1].vld && (r_prod[2*DW-1:DW] == '0)
                     && (mul_lo <= mul_lim);

    // stage next values
    always_comb begin
        n_sv          = {r_sv[NS-2:0], i_valid};
        n_stg[0].row  = i_job.row;
        n_stg[0].cmd  = i_job.cmd;
        n_stg[0].res  = i_job.res;
        n_stg[0].vld  = i_job.vld;
        n_stg[0].neg  = i_job.neg;
        n_stg[0].rem  = '0;
        n_stg[0].quo  = i_job.mag_a;
        n_stg[0].dvs  = i_job.mag_b;
        for (int i = 1; i < NS; i++) begin
            n_stg[i] = nai_pkg::div_step(r_stg[i-1]);
        end
        if (r_stg[nai_pkg::MUL_STAGE-1].cmd == nai_pkg::CMD_MUL) begin
            n_stg[nai_pkg::MUL_STAGE].vld = mul_ok;
            n_stg[nai_pkg::MUL_STAGE].res =
                !mul_ok ? '0 : (r_stg[nai_pkg::MUL_STAGE-1].neg ? (~mul_lo + 1'b1) : mul_lo);
        end
    end

    // final fix-up of the quotient sign
    always_comb begin
        n_vld = r_stg[NS-1].vld;
        n_val = r_stg[NS-1].res;
        if (r_stg[NS-1].cmd == nai_pkg::CMD_DIV) begin
            n_val = !r_stg[NS-1].vld ? '0
                  : (r_stg[NS-1].neg ? (~r_stg[NS-1].quo + 1'b1) : r_stg[NS-1].quo);
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv     <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_sv     <= n_sv;
            r_strobe <= r_sv[NS-1];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NS; i++) begin
            r_stg[i] <= n_stg[i];
        end
        r_pp_ll  <= r_stg[0].quo[HW-1:0]  * r_stg[0].dvs[HW-1:0];
        r_pp_lh  <= r_stg[0].quo[HW-1:0]  * r_stg[0].dvs[DW-1:HW];
        r_pp_hl  <= r_stg[0].quo[DW-1:HW] * r_stg[0].dvs[HW-1:0];
        r_pp_hh  <= r_stg[0].quo[DW-1:HW] * r_stg[0].dvs[DW-1:HW];
        r_m2_ll  <= r_pp_ll;
        r_m2_hh  <= r_pp_hh;
        r_m2_mid <= {1'b0, r_pp_lh} + {1'b0, r_pp_hl};
        r_prod   <= {r_m2_hh, r_m2_ll} + {{(DW-HW-1){1'b0}}, r_m2_mid, {HW{1'b0}}};
        r_row    <= r_stg[NS-1].row;
        r_val    <= n_val;
        r_vld    <= n_vld;
    end

    assign o_strobe        = r_strobe;
    assign o_out_row_index = r_row;
    assign o_result_value  = r_val;
    assign o_result_valid  = r_vld;

endmodule

>>> hdl/null_aware_int64_expression_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// null_aware_int64_expression_alu
// Per-row SQL expression ALU on nullable int64 operands.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive i_cmd, row index, operands and their valid bits
//   with start high; the request is taken at a rising edge where busy is low.
//   Result channel: o_strobe is high for one cycle with the row index,
//   result value and valid bit; it cannot be held off. A null result has
//   value zero. Results come out in request order.
//   Every request, whatever its command, travels through the queue, the
//   64-stage bit-per-stage divider and the output registers before its
//   result is strobed.
//   Throughput: one request per cycle; busy rises only if the request queue
//   fills, which does not happen while the back end drains it every cycle.
//   Reset (synchronous, active low) drops every request in flight.
// ----------------------------------------------------------------------------
module null_aware_int64_expression_alu #(
    parameter int QUEUE_DEPTH = nai_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [nai_pkg::CMD_W-1:0]         i_cmd,
    input  logic [nai_pkg::ROW_W-1:0]         i_row_index,
    input  logic signed [nai_pkg::DATA_W-1:0] i_operand_a,
    input  logic                              i_operand_a_valid,
    input  logic signed [nai_pkg::DATA_W-1:0] i_operand_b,
    input  logic                              i_operand_b_valid,
    output logic                              o_strobe,
    output logic [nai_pkg::ROW_W-1:0]         o_out_row_index,
    output logic signed [nai_pkg::DATA_W-1:0] o_result_value,
    output logic                              o_result_valid
);

    nai_pkg::t_job job_in;
    nai_pkg::t_job job_out;
    logic          q_empty;
    logic          q_full;

    assign busy = q_full;

    // classify
    nai_front u_front (
        .i_cmd             (i_cmd),
        .i_row_index       (i_row_index),
        .i_operand_a       (i_operand_a),
        .i_operand_a_valid (i_operand_a_valid),
        .i_operand_b       (i_operand_b),
        .i_operand_b_valid (i_operand_b_valid),
        .o_job             (job_in)
    );

    // decoupling queue
    nai_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start & ~q_full),
        .i_data  (job_in),
        .i_pop   (~q_empty),
        .o_data  (job_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // execute
    nai_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (~q_empty),
        .i_job           (job_out),
        .o_strobe        (o_strobe),
        .o_out_row_index (o_out_row_index),
        .o_result_value  (o_result_value),
        .o_result_valid  (o_result_valid)
    );

endmodule

>>> hdl/nai_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nai_checker
// Port-level checks of the expression ALU, bound to the top level.
// ----------------------------------------------------------------------------
module nai_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic [nai_pkg::CMD_W-1:0]         i_cmd,
    input logic [nai_pkg::ROW_W-1:0]         i_row_index,
    input logic                              o_strobe,
    input logic [nai_pkg::ROW_W-1:0]         o_out_row_index,
    input logic signed [nai_pkg::DATA_W-1:0] o_result_value,
    input logic                              o_result_valid
);

    // every result traces back to a request a fixed time earlier
    a_strobe_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, nai_pkg::LATENCY))
        else $error("result without matching request");

    // row index rides along unchanged
    a_row_passthrough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_out_row_index == $past(i_row_index, nai_pkg::LATENCY))
        else $error("row index mismatch");

    // null results are zero
    a_null_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result_valid |-> o_result_value == '0)
        else $error("null result with nonzero value");

    // IS NULL is never null
    a_isnull_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && ($past(i_cmd, nai_pkg::LATENCY) == nai_pkg::CMD_ISNULL)
        |-> o_result_valid)
        else $error("IS NULL produced null");

endmodule

bind null_aware_int64_expression_alu nai_checker u_nai_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_cmd           (i_cmd),
    .i_row_index     (i_row_index),
    .o_strobe        (o_strobe),
    .o_out_row_index (o_out_row_index),
    .o_result_value  (o_result_value),
    .o_result_valid  (o_result_valid)
);

>>> test/null_aware_int64_expression_alu_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// null_aware_int64_expression_alu_test
// Self-checking bench for the null-aware int64 expression ALU: a queue-fed
// driver sends requests, a predictor computes each expected row result, and
// a monitor compares strobed results in order, field by field.
// ----------------------------------------------------------------------------
module null_aware_int64_expression_alu_test;

    localparam int CMD_W  = nai_pkg::CMD_W;
    localparam int ROW_W  = nai_pkg::ROW_W;
    localparam int DATA_W = nai_pkg::DATA_W;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ROW_W-1:0]  row;
        logic [DATA_W-1:0] a;
        logic              av;
        logic [DATA_W-1:0] b;
        logic              bv;
    } t_req;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [DATA_W-1:0] value;
        logic              valid;
    } t_row_res;

    localparam logic [DATA_W-1:0] MIN64 = nai_pkg::SIGN_BIT;
    localparam logic [DATA_W-1:0] MAX64 = ~nai_pkg::SIGN_BIT;
    localparam logic [DATA_W-1:0] NEG1  = '1;
    localparam logic [CMD_W-1:0]  CMD_BAD_LO = 4'd14;
    localparam logic [CMD_W-1:0]  CMD_BAD_HI = 4'd15;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic [CMD_W-1:0] i_cmd;
    logic [ROW_W-1:0] i_row_index;
    logic signed [DATA_W-1:0] i_operand_a;
    logic i_operand_a_valid;
    logic signed [DATA_W-1:0] i_operand_b;
    logic i_operand_b_valid;
    logic o_strobe;
    logic [ROW_W-1:0] o_out_row_index;
    logic signed [DATA_W-1:0] o_result_value;
    logic o_result_valid;

    t_req     pending_reqs[$];
    t_row_res expected_rows[$];
    int       mismatches;
    int       gap_left;
    bit       quiet_tail;
    bit       hold_for_drain;
    bit       taken;

    null_aware_int64_expression_alu dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .i_row_index(i_row_index),
        .i_operand_a(i_operand_a), .i_operand_a_valid(i_operand_a_valid),
        .i_operand_b(i_operand_b), .i_operand_b_valid(i_operand_b_valid),
        .o_strobe(o_strobe), .o_out_row_index(o_out_row_index),
        .o_result_value(o_result_value), .o_result_valid(o_result_valid)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [DATA_W-1:0] abs64(logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? -v : v;
    endfunction

    // expected row result of one request
    function automatic t_row_res row_result(t_req q);
        t_row_res   r;
        logic [DATA_W-1:0] s;
        logic [2*DATA_W-1:0] p;
        logic [DATA_W-1:0] mq;
        logic both, neg, x, y, is_and;
        both   = q.av && q.bv;
        r.row  = q.row;
        r.value = '0;
        r.valid = 1'b0;
        case (q.cmd)
            nai_pkg::CMD_ADD: begin
                s = q.a + q.b;
                r.value = s;
                r.valid = both && !((~(q.a ^ q.b) & (q.a ^ s)) & nai_pkg::SIGN_BIT);
            end
            nai_pkg::CMD_SUB: begin
                s = q.a - q.b;
                r.value = s;
                r.valid = both && !(((q.a ^ q.b) & (q.a ^ s)) & nai_pkg::SIGN_BIT);
            end
            nai_pkg::CMD_MUL: begin
                neg = q.a[DATA_W-1] ^ q.b[DATA_W-1];
                p = {64'd0, abs64(q.a)} * {64'd0, abs64(q.b)};
                r.valid = both && p[2*DATA_W-1:DATA_W] == '0 &&
                          (neg ? p[DATA_W-1:0] <= MIN64 : p[DATA_W-1:0] <= MAX64);
                r.value = neg ? -p[DATA_W-1:0] : p[DATA_W-1:0];
            end
            nai_pkg::CMD_DIV: begin
                r.valid = both && q.b != '0 && !(q.a == MIN64 && q.b == NEG1);
                if (r.valid) begin
                    mq = abs64(q.a) / abs64(q.b);
                    r.value = (q.a[DATA_W-1] ^ q.b[DATA_W-1]) ? -mq : mq;
                end
            end
            nai_pkg::CMD_EQ: begin
                r.value = DATA_W'(q.a == q.b);
                r.valid = both;
            end
            nai_pkg::CMD_NE: begin
                r.value = DATA_W'(q.a != q.b);
                r.valid = both;
            end
            nai_pkg::CMD_LT: begin
                r.value = DATA_W'($signed(q.a) <  $signed(q.b));
                r.valid = both;
            end
            nai_pkg::CMD_LE: begin
                r.value = DATA_W'($signed(q.a) <= $signed(q.b));
                r.valid = both;
            end
            nai_pkg::CMD_GT: begin
                r.value = DATA_W'($signed(q.a) >  $signed(q.b));
                r.valid = both;
            end
            nai_pkg::CMD_GE: begin
                r.value = DATA_W'($signed(q.a) >= $signed(q.b));
                r.valid = both;
            end
            nai_pkg::CMD_AND, nai_pkg::CMD_OR: begin
                x = q.a != '0;
                y = q.b != '0;
                is_and = q.cmd == nai_pkg::CMD_AND;
                r.value = DATA_W'(is_and ? (x && y) : (x || y));
                // Kleene: a known dominant operand decides the result
                r.valid = both || (q.av && x != is_and) || (q.bv && y != is_and);
            end
            nai_pkg::CMD_NOT: begin
                r.value = DATA_W'(q.a == '0);
                r.valid = q.av;
            end
            nai_pkg::CMD_ISNULL: begin
                r.value = DATA_W'(!q.av);
                r.valid = 1'b1;
            end
            default: r.valid = 1'b0;
        endcase
        if (!r.valid)
            r.value = '0;
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return MIN64;
            1: return MAX64;
            2: return NEG1;
            3: return '0;
            4: return 64'($urandom_range(0, 1));
            5: return 64'(signed'($urandom_range(0, 200)) - 100);
            6: return {{32{$urandom_range(0, 1) == 1}}, 32'($urandom)};
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic t_req rand_req();
        t_req q;
        q.cmd = ($urandom_range(0, 49) == 0) ? 4'($urandom_range(14, 15))
                                             : 4'($urandom_range(0, 13));
        q.row = 10'($urandom);
        q.a   = rand_operand();
        q.b   = rand_operand();
        // keep products in range often enough to see valid multiplies
        if (q.cmd == nai_pkg::CMD_MUL && $urandom_range(0, 1) == 1) begin
            q.a = {{32{q.a[31]}}, q.a[31:0]};
            q.b = {{33{q.b[30]}}, q.b[30:0]};
        end
        q.av  = $urandom_range(0, 5) != 0;
        q.bv  = $urandom_range(0, 5) != 0;
        return q;
    endfunction

    function automatic t_req mk(logic [CMD_W-1:0] c, logic [ROW_W-1:0] row,
                                logic [DATA_W-1:0] a, logic av,
                                logic [DATA_W-1:0] b, logic bv);
        t_req q;
        q.cmd = c; q.row = row; q.a = a; q.av = av; q.b = b; q.bv = bv;
        return q;
    endfunction

    // append a request to the pending list
    function automatic void queue_req(t_req q);
        pending_reqs.insert(pending_reqs.size(), q);
    endfunction

    // driver: one request per accepting edge, random idle bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !taken) begin
            // hold the current request until it is taken
        end else begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (hold_for_drain && expected_rows.size() != 0) begin
                start <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                t_req q;
                q = pending_reqs[0];
                if (!quiet_tail && $urandom_range(0, 14) == 0)
                    gap_left <= $urandom_range(1, 19);
                start <= (!quiet_tail && $urandom_range(0, 14) == 0) ? 1'b0 : 1'b1;
                i_cmd <= q.cmd;
                i_row_index <= q.row;
                i_operand_a <= q.a;
                i_operand_a_valid <= q.av;
                i_operand_b <= q.b;
                i_operand_b_valid <= q.bv;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: predict on accept, compare on strobe
    always @(posedge i_clk) begin
        t_row_res got, want;
        taken = i_rst_n && start && !busy;
        if (taken) begin
            expected_rows.insert(expected_rows.size(), row_result(pending_reqs[0]));
            void'(pending_reqs.pop_front());
        end
        if (i_rst_n && o_strobe) begin
            got.row = o_out_row_index;
            got.value = o_result_value;
            got.valid = o_result_valid;
            if (expected_rows.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: row %0d value %h valid %b",
                             got.row, got.value, got.valid);
            end else begin
                want = expected_rows.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected row %0d value %h valid %b, ",
                                  "got row %0d value %h valid %b"},
                                 want.row, want.value, want.valid,
                                 got.row, got.value, got.valid);
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        logic [CMD_W-1:0] c;
        int wait_cycles;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        i_row_index = '0;
        i_operand_a = '0;
        i_operand_a_valid = 1'b0;
        i_operand_b = '0;
        i_operand_b_valid = 1'b0;
        mismatches = 0;
        gap_left = 0;
        quiet_tail = 1'b0;
        hold_for_drain = 1'b0;
        taken = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: overflow edges, division corners, three-valued logic, undefined commands, compares
        queue_req(mk(nai_pkg::CMD_ADD, 10'd0, MAX64, 1'b1, 64'd1, 1'b1));
        queue_req(mk(nai_pkg::CMD_ADD, 10'h3ff, MIN64, 1'b1, NEG1, 1'b1));
        queue_req(mk(nai_pkg::CMD_SUB, 10'd1, MIN64, 1'b1, 64'd1, 1'b1));
        queue_req(mk(nai_pkg::CMD_SUB, 10'd2, 64'd0, 1'b1, MIN64, 1'b1));
        queue_req(mk(nai_pkg::CMD_MUL, 10'd3, MIN64, 1'b1, 64'd1, 1'b1));
        queue_req(mk(nai_pkg::CMD_MUL, 10'd4, MIN64, 1'b1, NEG1, 1'b1));
        queue_req(mk(nai_pkg::CMD_MUL, 10'd5, 64'h1_0000_0000, 1'b1,
                     64'hffff_ffff_8000_0000, 1'b1));
        queue_req(mk(nai_pkg::CMD_DIV, 10'd6, MIN64, 1'b1, NEG1, 1'b1));
        queue_req(mk(nai_pkg::CMD_DIV, 10'd7, 64'd7, 1'b1, 64'd0, 1'b1));
        queue_req(mk(nai_pkg::CMD_DIV, 10'd8, -64'd7, 1'b1, 64'd2, 1'b1));
        queue_req(mk(nai_pkg::CMD_DIV, 10'd9, MIN64, 1'b1, MAX64, 1'b1));
        queue_req(mk(nai_pkg::CMD_LT, 10'd10, MIN64, 1'b1, MAX64, 1'b1));
        queue_req(mk(nai_pkg::CMD_GE, 10'd11, NEG1, 1'b1, 64'd0, 1'b0));
        queue_req(mk(nai_pkg::CMD_AND, 10'd12, 64'd0, 1'b1, 64'd1, 1'b0));
        queue_req(mk(nai_pkg::CMD_AND, 10'd13, 64'd5, 1'b1, 64'd1, 1'b0));
        queue_req(mk(nai_pkg::CMD_OR, 10'd14, 64'd0, 1'b0, NEG1, 1'b1));
        queue_req(mk(nai_pkg::CMD_OR, 10'd15, 64'd0, 1'b1, 64'd0, 1'b0));
        queue_req(mk(nai_pkg::CMD_NOT, 10'd16, 64'd9, 1'b0, 64'd0, 1'b1));
        queue_req(mk(nai_pkg::CMD_NOT, 10'd17, 64'd0, 1'b1, 64'd0, 1'b0));
        queue_req(mk(nai_pkg::CMD_ISNULL, 10'd18, MAX64, 1'b0, 64'd0, 1'b0));
        queue_req(mk(CMD_BAD_LO, 10'd19, 64'd1, 1'b1, 64'd1, 1'b1));
        queue_req(mk(CMD_BAD_HI, 10'd20, 64'd1, 1'b1, 64'd1, 1'b1));
        for (int k = 0; k < 6; k++) begin
            c = (k < 2) ? nai_pkg::CMD_EQ : (k < 4) ? nai_pkg::CMD_NE :
                (k < 5) ? nai_pkg::CMD_LE : nai_pkg::CMD_GT;
            queue_req(mk(c, 10'(k), k[0] ? MAX64 : NEG1, 1'b1, NEG1, 1'b1));
        end

        // random body, with one full drain in the middle
        for (int n = 0; n < 850; n++) begin
            if (n == 400) begin
                wait (pending_reqs.size() == 0);
                hold_for_drain = 1'b1;
            end
            if (n == 420)
                hold_for_drain = 1'b0;
            if (n == 700)
                quiet_tail = 1'b1;
            queue_req(rand_req());
            if (pending_reqs.size() > 16)
                wait (pending_reqs.size() <= 16);
        end
        wait (pending_reqs.size() == 0 && !start);
        wait (expected_rows.size() == 0);
        for (wait_cycles = 0; wait_cycles < nai_pkg::LATENCY + 20; wait_cycles++)
            @(posedge i_clk);
        if (mismatches == 0 && expected_rows.size() == 0)
            $display("** null_aware_int64_expression_alu: PASSED **");
        else
            $display("** null_aware_int64_expression_alu: FAILED **");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("** null_aware_int64_expression_alu: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
hdl/nai_pkg.sv
hdl/nai_front.sv
hdl/nai_queue.sv
hdl/nai_back.sv
hdl/null_aware_int64_expression_alu.sv
hdl/nai_checker.sv
test/null_aware_int64_expression_alu_test.sv
